### rtl/core/cpd_pkg.sv
// Shared constants, types and state codes for the closest pair distance block.
`default_nettype none

package cpd_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int COORD_W     = 24;
  localparam int LIMIT_W     = 25;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SQ_W        = PROD_W + 1;
  localparam int BEST_W      = 50;
  localparam int SQRT_ITERS  = BEST_W / 2;
  localparam int ITER_W      = $clog2(SQRT_ITERS);
  localparam int REM_W       = LIMIT_W + 3;
  localparam int PAIR_W      = 2 * COORD_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(160000);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [BEST_W-1:0]         best_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQRT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/core/cpd_if.sv
// Point, result and configuration channel interfaces of the closest pair distance block.
`default_nettype none

interface cpd_point_if;
  logic            valid;
  logic            ready;
  cpd_pkg::coord_t x_coord;
  cpd_pkg::coord_t y_coord;
  logic            last_point;

  modport source (output valid, x_coord, y_coord, last_point, input ready);
  modport sink (input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface cpd_result_if;
  logic            valid;
  logic            ready;
  cpd_pkg::limit_t min_distance;
  cpd_pkg::sq_t    min_distance_squared;
  logic            none_closer;
  logic            too_few_points;
  logic            overflowed;

  modport source (output valid, min_distance, min_distance_squared, none_closer,
                  too_few_points, overflowed, input ready);
  modport sink (input valid, min_distance, min_distance_squared, none_closer,
                too_few_points, overflowed, output ready);
endinterface

interface cpd_cfg_if;
  logic            valid;
  logic            ready;
  cpd_pkg::limit_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/cpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/closest_pair_distance.sv
// Top level of the closest pair distance block: point store, distance scan and square root.
//
// Points arrive one beat at a time and are kept in a 1024-entry RAM. Each new
// point is compared against every stored point, one RAM read per cycle, through
// a four-stage difference, square and compare pipeline; the single RAM read
// port sets the pace of that scan. The beat that carries last_point then passes
// through a bit-serial square root before the result beat is offered.
// The result sits in an output register, and the next set may start while it
// waits. Once 1024 points are stored, further points are dropped and flagged.
// Configuration writes are taken at any time but belong between sets.
`default_nettype none

module closest_pair_distance (
  input wire logic    clk,
  input wire logic    rst,
  cpd_point_if.sink   point,
  cpd_cfg_if.sink     cfg,
  cpd_result_if.source result
);

  import cpd_pkg::*;

  state_t state;
  state_t state_next;

  logic   point_ready;
  logic   rd_en;
  logic   ram_we;
  logic   pipe_busy;
  logic   too_few;
  logic   store_full;

  count_t point_count;
  count_t scan_idx;
  best_t  best;
  logic   overflow_seen;
  limit_t limit;
  logic   v1;
  logic   v2;
  logic   v3;
  logic   res_valid;
  logic [ITER_W-1:0] iter;

  coord_t cur_x;
  coord_t cur_y;
  logic   cur_last;
  logic [PAIR_W-1:0] rd_data;
  coord_t rd_x;
  coord_t rd_y;
  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  logic signed [COORD_W:0] mag_x;
  logic signed [COORD_W:0] mag_y;
  logic [COORD_W-1:0] dx_abs;
  logic [COORD_W-1:0] dy_abs;
  logic [PROD_W-1:0]  sqx;
  logic [PROD_W-1:0]  sqy;
  sq_t    sum;

  sq_t    sq_hold;
  best_t  sq_sr;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_shift;
  logic [REM_W-1:0]   trial;
  limit_t root;

  limit_t res_dist;
  sq_t    res_sq;
  logic   res_none;
  logic   res_few;
  logic   res_ovf;

  assign point.ready = point_ready;
  assign cfg.ready   = 1'b1;

  assign result.valid                = res_valid;
  assign result.min_distance         = res_dist;
  assign result.min_distance_squared = res_sq;
  assign result.none_closer          = res_none;
  assign result.too_few_points       = res_few;
  assign result.overflowed           = res_ovf;

  assign pipe_busy  = v1 || v2 || v3;
  assign too_few    = point_count < CNT_W'(2);
  assign store_full = point_count == CNT_W'(MAX_POINTS);

  cpd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata ({cur_x, cur_y}),
    .re    (rd_en),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign rd_x   = rd_data[PAIR_W-1:COORD_W];
  assign rd_y   = rd_data[COORD_W-1:0];
  assign diff_x = {cur_x[COORD_W-1], cur_x} - {rd_x[COORD_W-1], rd_x};
  assign diff_y = {cur_y[COORD_W-1], cur_y} - {rd_y[COORD_W-1], rd_y};
  assign mag_x  = diff_x[COORD_W] ? -diff_x : diff_x;
  assign mag_y  = diff_y[COORD_W] ? -diff_y : diff_y;
  assign sum    = {1'b0, sqx} + {1'b0, sqy};

  assign rem_shift = {rem[REM_W-3:0], sq_sr[BEST_W-1:BEST_W-2]};
  assign trial     = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    point_ready = 1'b0;
    rd_en       = 1'b0;
    ram_we      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        point_ready = 1'b1;
        if (point.valid) begin
          if (store_full) begin
            state_next = point.last_point ? ST_SQRT : ST_IDLE;
          end else if (point_count == '0) begin
            state_next = ST_DRAIN;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_idx + CNT_W'(1) == point_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          ram_we     = 1'b1;
          state_next = cur_last ? ST_SQRT : ST_IDLE;
        end
      end
      ST_SQRT: begin
        if (too_few || iter == ITER_W'(SQRT_ITERS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!res_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      scan_idx      <= '0;
      best          <= '1;
      overflow_seen <= 1'b0;
      limit         <= LIMIT_RESET;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      res_valid     <= 1'b0;
      iter          <= '0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.data;
      end
      if (point.valid && point_ready) begin
        scan_idx <= '0;
        if (store_full) begin
          overflow_seen <= 1'b1;
        end
      end else if (rd_en) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      if (v3 && {1'b0, sum} < best) begin
        best <= {1'b0, sum};
      end
      if (state == ST_SQRT) begin
        iter <= iter + ITER_W'(1);
      end else begin
        iter <= '0;
      end
      if (state == ST_FIN && !res_valid) begin
        res_valid     <= 1'b1;
        point_count   <= '0;
        best          <= '1;
        overflow_seen <= 1'b0;
      end else begin
        if (ram_we) begin
          point_count <= point_count + CNT_W'(1);
        end
        if (result.valid && result.ready) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (point.valid && point_ready) begin
      cur_x    <= point.x_coord;
      cur_y    <= point.y_coord;
      cur_last <= point.last_point;
    end
    if (v1) begin
      dx_abs <= mag_x[COORD_W-1:0];
      dy_abs <= mag_y[COORD_W-1:0];
    end
    if (v2) begin
      sqx <= dx_abs * dx_abs;
      sqy <= dy_abs * dy_abs;
    end
    if (state_next == ST_SQRT && state != ST_SQRT) begin
      sq_hold <= best[SQ_W-1:0];
      sq_sr   <= {1'b0, best[SQ_W-1:0]};
      rem     <= '0;
      root    <= '0;
    end else if (state == ST_SQRT) begin
      sq_sr <= {sq_sr[BEST_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[LIMIT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[LIMIT_W-2:0], 1'b0};
      end
    end
    if (state == ST_FIN && !res_valid) begin
      res_ovf <= overflow_seen;
      if (too_few) begin
        res_dist <= '0;
        res_sq   <= '0;
        res_none <= 1'b0;
        res_few  <= 1'b1;
      end else begin
        res_dist <= root;
        res_sq   <= sq_hold;
        res_none <= root >= limit;
        res_few  <= 1'b0;
      end
    end
  end

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the finish state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store capacity");

  a_write_after_drain: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !pipe_busy && !rd_en)
    else $error("store written while the scan is still in flight");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> scan_idx < point_count)
    else $error("scan read beyond stored points");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pipe_busy |-> !point_ready)
    else $error("point taken while a scan is in flight");

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for the closest pair distance block with a point-set predictor and random flow control.
`timescale 1ns / 100ps

module tb_top;
  import cpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RECEIVER_HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam limit_t LIMIT_MAX = limit_t'(23726566);
  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } point_beat_t;

  typedef struct {
    limit_t min_distance;
    sq_t    min_sq;
    logic   none_closer;
    logic   too_few;
    logic   overflowed;
  } distance_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpd_point_if  point_bus ();
  cpd_result_if result_bus ();
  cpd_cfg_if    cfg_bus ();

  closest_pair_distance dut (
    .clk   (clk),
    .rst   (rst),
    .point (point_bus),
    .cfg   (cfg_bus),
    .result(result_bus)
  );

  always #5 clk = ~clk;

  point_beat_t      pending_points[$];
  distance_result_t expected_distances[$];

  coord_t              stored_x[MAX_POINTS];
  coord_t              stored_y[MAX_POINTS];
  int                  stored_count = 0;
  logic [BEST_W-1:0]   closest_sq = '1;
  logic                dropped_points = 1'b0;
  limit_t              limit_mirror = LIMIT_RESET;

  int   mismatches = 0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   recv_gap = 0;
  int   recv_calm = 0;
  int   stall_cycles = 0;
  logic receiver_hold = 1'b0;
  logic pressure_go = 1'b0;

  function automatic longint unsigned floor_sqrt(input longint unsigned value);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned step_bit;
    rem = value;
    root = 0;
    step_bit = 64'd1 << 62;
    while (step_bit > rem) step_bit >>= 2;
    while (step_bit != 0) begin
      if (rem >= root + step_bit) begin
        rem -= root + step_bit;
        root = (root >> 1) + step_bit;
      end else begin
        root >>= 1;
      end
      step_bit >>= 2;
    end
    return root;
  endfunction

  task automatic absorb_point(input point_beat_t p);
    longint dx;
    longint dy;
    longint unsigned sq;
    longint unsigned root;
    distance_result_t r;
    int i;
    if (stored_count < MAX_POINTS) begin
      for (i = 0; i < stored_count; i++) begin
        dx = longint'(p.x) - longint'(stored_x[i]);
        dy = longint'(p.y) - longint'(stored_y[i]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = longint'(dx * dx) + longint'(dy * dy);
        if (BEST_W'(sq) < closest_sq) closest_sq = BEST_W'(sq);
      end
      stored_x[stored_count] = p.x;
      stored_y[stored_count] = p.y;
      stored_count++;
    end else begin
      dropped_points = 1'b1;
    end
    if (p.last) begin
      if (stored_count < 2) begin
        r.min_distance = '0;
        r.min_sq = '0;
        r.none_closer = 1'b0;
        r.too_few = 1'b1;
      end else begin
        sq = longint'(closest_sq[SQ_W-1:0]);
        root = floor_sqrt(sq);
        r.min_distance = root[LIMIT_W-1:0];
        r.min_sq = sq[SQ_W-1:0];
        r.none_closer = (root >= longint'(limit_mirror));
        r.too_few = 1'b0;
      end
      r.overflowed = dropped_points;
      expected_distances = {expected_distances, r};
      stored_count = 0;
      closest_sq = '1;
      dropped_points = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    distance_result_t want;
    if (expected_distances.size() == 0) begin
      report_mismatch("result beat with none pending", 1, 0);
      return;
    end
    want = expected_distances.pop_front();
    if (result_bus.min_distance !== want.min_distance)
      report_mismatch("min_distance", result_bus.min_distance, want.min_distance);
    if (result_bus.min_distance_squared !== want.min_sq)
      report_mismatch("min_distance_squared", result_bus.min_distance_squared, want.min_sq);
    if (result_bus.none_closer !== want.none_closer)
      report_mismatch("none_closer", result_bus.none_closer, want.none_closer);
    if (result_bus.too_few_points !== want.too_few)
      report_mismatch("too_few_points", result_bus.too_few_points, want.too_few);
    if (result_bus.overflowed !== want.overflowed)
      report_mismatch("overflowed", result_bus.overflowed, want.overflowed);
  endtask

  function automatic int pick_gap(inout int calm_left);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if (roll < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      point_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (point_bus.valid && point_bus.ready) begin
        absorb_point(pending_points.pop_front());
        send_gap = pick_gap(send_calm);
      end
      if (send_gap != 0) begin
        send_gap--;
        point_bus.valid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        point_bus.valid <= 1'b1;
        point_bus.x_coord <= pending_points[0].x;
        point_bus.y_coord <= pending_points[0].y;
        point_bus.last_point <= pending_points[0].last;
      end else begin
        point_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic fired;
    fired = result_bus.valid && result_bus.ready;
    if (rst) begin
      result_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (fired) check_result();
      if (receiver_hold) begin
        result_bus.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (fired || $urandom_range(0, 7) == 0) recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // The receiver stops taking results for a long stretch so the block backs up.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (RECEIVER_HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_point(input coord_t x, input coord_t y, input logic last);
    point_beat_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    pending_points = {pending_points, p};
  endtask

  task automatic queue_random_set(input int size);
    int span;
    int n;
    int roll;
    coord_t base;
    logic [COORD_W-1:0] mask;
    point_beat_t p;
    span = $urandom_range(1, COORD_W);
    mask = (COORD_W'(1) << span) - COORD_W'(1);
    base = coord_t'($urandom);
    p.x = base;
    p.y = base;
    for (n = 0; n < size; n++) begin
      roll = $urandom_range(0, 15);
      if (n == 0 || roll > 1) begin
        p.x = base + coord_t'(COORD_W'($urandom) & mask);
        p.y = base + coord_t'(COORD_W'($urandom) & mask);
      end
      if (roll == 1) begin
        p.x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        p.y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
      p.last = (n == size - 1);
      pending_points = {pending_points, p};
    end
  endtask

  task automatic queue_random_sets(input int items, input int max_size);
    int queued;
    int size;
    int roll;
    queued = 0;
    while (queued < items) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) size = $urandom_range(1, 6);
      else if (roll < 9) size = $urandom_range(7, 20);
      else size = $urandom_range(21, 64);
      if (size > max_size) size = $urandom_range(1, max_size);
      queue_random_set(size);
      queued += size;
    end
  endtask

  task automatic drain_phase();
    while (pending_points.size() != 0 || point_bus.valid || expected_distances.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input limit_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    limit_mirror = value;
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    point_bus.valid = 1'b0;
    point_bus.x_coord = '0;
    point_bus.y_coord = '0;
    point_bus.last_point = 1'b0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    queue_point(0, 0, 1'b1);
    queue_point(COORD_MAX, COORD_MAX, 1'b0);
    queue_point(COORD_MIN, COORD_MIN, 1'b1);
    queue_point(COORD_MIN, COORD_MAX, 1'b0);
    queue_point(COORD_MAX, COORD_MIN, 1'b0);
    queue_point(3, -3, 1'b0);
    queue_point(3, -3, 1'b1);
    queue_point(24'sh555555, 24'shAAAAAA, 1'b0);
    queue_point(24'shAAAAAA, 24'sh555555, 1'b0);
    queue_point(24'sh555554, 24'shAAAAAB, 1'b1);
    queue_point(0, 0, 1'b0);
    queue_point(160000, 0, 1'b1);
    queue_point(0, 0, 1'b0);
    queue_point(0, 159999, 1'b1);
    drain_phase();

    write_limit(limit_t'(16));
    queue_point(0, 0, 1'b0);
    queue_point(16, 0, 1'b1);
    queue_point(0, 0, 1'b0);
    queue_point(0, 15, 1'b1);
    queue_point(7, 7, 1'b0);
    queue_point(-7, -7, 1'b1);
    drain_phase();

    write_limit('0);
    queue_random_sets(100, 64);
    drain_phase();

    write_limit(LIMIT_MAX);
    queue_random_sets(100, 64);
    drain_phase();

    write_limit(limit_t'($urandom_range(0, 23726566)));
    pressure_go = 1'b1;
    queue_random_sets(100, 4);
    drain_phase();

    write_limit(limit_t'($urandom_range(0, 23726566)));
    queue_random_sets(100, 64);
    drain_phase();

    write_limit(LIMIT_RESET);
    queue_random_sets(130, 64);
    drain_phase();

    if (mismatches == 0 && expected_distances.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### closest_pair_distance.f
rtl/core/cpd_pkg.sv
rtl/core/cpd_if.sv
rtl/core/cpd_ram.sv
rtl/core/closest_pair_distance.sv
test/tb_top.sv
